// ===== hdl/gdc_pkg.sv =====
// Shared types and constants for the gesture direction classifier.
`timescale 1ns / 1ps
`default_nettype none
package gdc_pkg;
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_BATCH  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [1:0] CFG_VALID_LEVEL = 2'd0;
  localparam logic [1:0] CFG_SWIPE_SENS  = 2'd1;
  localparam logic [1:0] CFG_STILL_SENS  = 2'd2;

  localparam logic [2:0] MOT_NONE  = 3'd0;
  localparam logic [2:0] MOT_LEFT  = 3'd1;
  localparam logic [2:0] MOT_RIGHT = 3'd2;
  localparam logic [2:0] MOT_UP    = 3'd3;
  localparam logic [2:0] MOT_DOWN  = 3'd4;
  localparam logic [2:0] MOT_NEAR  = 3'd5;
  localparam logic [2:0] MOT_FAR   = 3'd6;

  localparam logic [1:0] PROX_NONE = 2'd0;
  localparam logic [1:0] PROX_NEAR = 2'd1;
  localparam logic [1:0] PROX_FAR  = 2'd2;

  localparam int RATIO_BITS = 8;   // ratio in -100..100
  localparam int DELTA_BITS = 9;   // delta in -200..200
endpackage
`default_nettype wire

// ===== hdl/gesture_direction_classifier.sv =====
// Top level of the four-channel swipe gesture classifier.
// Usage: each input beat carries a kind and four photodiode levels. Kind
// store sample writes the levels into the batch RAM unless it is full; kind
// end of batch, if it holds more than MIN_SAMPLES samples, scans the RAM,
// finds first and last samples with all four levels above valid_level and,
// if found, forms four percent ratios and updates the direction sums,
// signs, near/far tallies and proximity state; kind end of gesture decodes
// one motion code and clears the gesture state. Every input beat yields
// exactly one output beat (motion, near_far_seen, sample_dropped).
// A batch end makes a forward and a backward pass over the RAM, one read
// per cycle through its single read port, then four ratio divisions one
// after another on one shared 15-step restoring divider. A short batch is
// answered without a scan, one with no valid sample after the forward pass.
// One item is in flight at a time; the output register holds a result until
// the receiver drops out_stall_i, and input is not taken while it is full.
// Reset empties the batch, clears all gesture state and loads the register
// defaults (valid level 10, swipe 50, still 20). The batch RAM is not
// cleared: only entries written in the current batch are read.
`timescale 1ns / 1ps
`default_nettype none
module gesture_direction_classifier #(
  parameter int BATCH_DEPTH = 32,
  parameter int MIN_SAMPLES = 4,
  parameter int NEAR_LIMIT  = 10,
  parameter int FAR_LIMIT   = 2,
  parameter int SUM_BITS    = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] up_level_i,
  input  wire logic [7:0] down_level_i,
  input  wire logic [7:0] left_level_i,
  input  wire logic [7:0] right_level_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      motion_o,
  output logic            near_far_seen_o,
  output logic            sample_dropped_o
);
  import gdc_pkg::*;

  localparam int AW = $clog2(BATCH_DEPTH);
  localparam int CW = $clog2(BATCH_DEPTH + 1);
  localparam logic signed [SUM_BITS-1:0] SumMax = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SumMin = {1'b1, {(SUM_BITS-1){1'b0}}};

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FWD   = 4'd1;  // forward scan, read issued
  localparam logic [3:0] S_BWD   = 4'd2;  // backward scan
  localparam logic [3:0] S_RDF   = 4'd3;  // read first sample
  localparam logic [3:0] S_RDL   = 4'd4;  // read last sample
  localparam logic [3:0] S_DIV   = 4'd5;  // divisions
  localparam logic [3:0] S_ACC   = 4'd6;  // update sums
  localparam logic [3:0] S_NF    = 4'd7;  // still / near-far update
  localparam logic [3:0] S_DONE  = 4'd8;  // never entered; S_NF gives the batch result
  localparam logic [3:0] S_GEND  = 4'd9;  // gesture end decode

  logic [3:0] st_q, st_d;
  logic [7:0] valid_level_q, swipe_q, still_q;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d, first_q, first_d, last_q, last_d;
  logic [AW-1:0] raddr;
  logic          rvalid_q, rvalid_d;   // divider run issued for dsel_q
  logic [31:0]   rdata, first_s_q, first_s_d, last_s_q, last_s_d;
  logic signed [SUM_BITS-1:0] vsum_q, vsum_d, hsum_q, hsum_d;
  logic signed [1:0] vsign_q, vsign_d, hsign_q, hsign_d;
  logic [7:0] near_q, near_d, far_q, far_d;
  logic [1:0] prox_q, prox_d;
  logic [2:0] lastm_q, lastm_d;
  logic signed [RATIO_BITS-1:0] rat_q [4];
  logic signed [RATIO_BITS-1:0] rat_d [4];
  logic [1:0] dsel_q, dsel_d;
  logic       dstart;
  logic [7:0] da, db;
  logic       ddone;
  logic signed [RATIO_BITS-1:0] dres;
  logic signed [DELTA_BITS-1:0] ud_q, ud_d, lr_q, lr_d;
  logic       we;
  logic       accept;
  logic       ovalid_q, ovalid_d;
  logic [2:0] omot_q, omot_d;
  logic       oseen_q, oseen_d, odrop_q, odrop_d;

  function automatic logic is_valid(input logic [31:0] s, input logic [7:0] lvl);
    is_valid = (s[31:24] > lvl) && (s[23:16] > lvl) && (s[15:8] > lvl) && (s[7:0] > lvl);
  endfunction

  function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0] s, input logic signed [DELTA_BITS-1:0] d);
    logic signed [SUM_BITS:0] t;
    t = {s[SUM_BITS-1], s} + (SUM_BITS+1)'(d);
    if (t > $signed({SumMax[SUM_BITS-1], SumMax})) sat_add = SumMax;
    else if (t < $signed({SumMin[SUM_BITS-1], SumMin})) sat_add = SumMin;
    else sat_add = t[SUM_BITS-1:0];
  endfunction

  function automatic logic signed [1:0] sign_of(
      input logic signed [SUM_BITS-1:0] s, input logic [7:0] th);
    logic signed [SUM_BITS:0] w, t;
    w = {s[SUM_BITS-1], s};
    t = (SUM_BITS+1)'({1'b0, th});
    if (w >= t) sign_of = 2'sd1;
    else if (w <= -t) sign_of = -2'sd1;
    else sign_of = 2'sd0;
  endfunction

  function automatic logic [2:0] decode(
      input logic [1:0] prox, input logic signed [1:0] vs, input logic signed [1:0] hs,
      input logic signed [SUM_BITS-1:0] v, input logic signed [SUM_BITS-1:0] h,
      input logic [2:0] cur);
    logic [SUM_BITS:0] mv, mh;
    mv = v[SUM_BITS-1] ? -{1'b1, v} : {1'b0, v};
    mh = h[SUM_BITS-1] ? -{1'b1, h} : {1'b0, h};
    if (prox == PROX_NEAR) decode = MOT_NEAR;
    else if (prox == PROX_FAR) decode = MOT_FAR;
    else if (vs == 2'sd0 && hs == 2'sd0) decode = cur;
    else if (hs == 2'sd0) decode = (vs < 0) ? MOT_UP : MOT_DOWN;
    else if (vs == 2'sd0) decode = (hs > 0) ? MOT_RIGHT : MOT_LEFT;
    else if (mv > mh) decode = (vs < 0) ? MOT_UP : MOT_DOWN;
    else decode = (hs > 0) ? MOT_RIGHT : MOT_LEFT;
  endfunction

  assign in_stall_o = (st_q != S_IDLE) || ovalid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign we         = accept && kind_i == KIND_SAMPLE && count_q < CW'(BATCH_DEPTH);

  gdc_ram #(.Width(32), .Depth(BATCH_DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({up_level_i, down_level_i, left_level_i, right_level_i}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign da = (dsel_q == 2'd0) ? first_s_q[31:24] : (dsel_q == 2'd1) ? first_s_q[15:8] :
              (dsel_q == 2'd2) ? last_s_q[31:24] : last_s_q[15:8];
  assign db = (dsel_q == 2'd0) ? first_s_q[23:16] : (dsel_q == 2'd1) ? first_s_q[7:0] :
              (dsel_q == 2'd2) ? last_s_q[23:16] : last_s_q[7:0];

  gdc_ratio_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart),
    .a_i    (da),
    .b_i    (db),
    .done_o (ddone),
    .ratio_o(dres)
  );

  always_comb begin
    logic still, zero;
    still    = 1'b0;
    zero     = 1'b0;
    st_d     = st_q;
    count_d  = count_q;
    idx_d    = idx_q;
    first_d  = first_q;
    last_d   = last_q;
    rvalid_d = 1'b0;
    raddr    = idx_q;
    first_s_d = first_s_q;
    last_s_d  = last_s_q;
    vsum_d = vsum_q;  hsum_d = hsum_q;
    vsign_d = vsign_q; hsign_d = hsign_q;
    near_d = near_q;  far_d = far_q;
    prox_d = prox_q;  lastm_d = lastm_q;
    rat_d  = rat_q;
    dsel_d = dsel_q;
    dstart = 1'b0;
    ud_d = ud_q; lr_d = lr_q;
    ovalid_d = ovalid_q && out_stall_i;
    omot_d = omot_q; oseen_d = oseen_q; odrop_d = odrop_q;

    unique case (st_q)
      S_IDLE: begin
        raddr = '0;
        if (accept) begin
          unique case (kind_i)
            KIND_SAMPLE: begin
              ovalid_d = 1'b1; omot_d = MOT_NONE; oseen_d = 1'b0;
              odrop_d  = !we;
              if (we) count_d = count_q + CW'(1);
            end
            KIND_BATCH: begin
              if (count_q <= CW'(MIN_SAMPLES)) begin
                count_d = '0;
                ovalid_d = 1'b1; omot_d = MOT_NONE; oseen_d = 1'b0; odrop_d = 1'b0;
              end else begin
                idx_d = '0; rvalid_d = 1'b1; st_d = S_FWD;
              end
            end
            KIND_END: st_d = S_GEND;
            default: begin
              ovalid_d = 1'b1; omot_d = MOT_NONE; oseen_d = 1'b0; odrop_d = 1'b0;
            end
          endcase
        end
      end
      S_FWD: begin
        // rdata is entry idx_q
        if (is_valid(rdata, valid_level_q)) begin
          first_d = idx_q;
          idx_d = AW'(count_q - CW'(1));
          raddr = AW'(count_q - CW'(1));
          st_d  = S_BWD;
        end else if ({1'b0, idx_q} == (AW+1)'(count_q - CW'(1))) begin
          count_d = '0; st_d = S_IDLE;
          ovalid_d = 1'b1; omot_d = MOT_NONE; oseen_d = 1'b0; odrop_d = 1'b0;
        end else begin
          idx_d = idx_q + AW'(1);
          raddr = idx_q + AW'(1);
        end
      end
      S_BWD: begin
        if (is_valid(rdata, valid_level_q)) begin
          last_d = idx_q; raddr = first_q; st_d = S_RDF;
        end else begin
          idx_d = idx_q - AW'(1);
          raddr = idx_q - AW'(1);
        end
      end
      S_RDF: begin
        raddr = last_q;
        first_s_d = rdata;
        st_d = S_RDL;
      end
      S_RDL: begin
        last_s_d = rdata;
        dsel_d = 2'd0;
        st_d = S_DIV;
        dstart = 1'b0;
      end
      S_DIV: begin
        // start divider on entry and after each completion
        if (!rvalid_q && !ddone) begin
          dstart = 1'b1;
          rvalid_d = 1'b1;
        end else if (ddone) begin
          rat_d[dsel_q] = dres;
          if (dsel_q == 2'd3) st_d = S_ACC;
          else begin
            dsel_d = dsel_q + 2'd1;
          end
        end else begin
          rvalid_d = 1'b1;
        end
      end
      S_ACC: begin
        ud_d = DELTA_BITS'(rat_q[2]) - DELTA_BITS'(rat_q[0]);
        lr_d = DELTA_BITS'(rat_q[3]) - DELTA_BITS'(rat_q[1]);
        vsum_d = sat_add(vsum_q, DELTA_BITS'(rat_q[2]) - DELTA_BITS'(rat_q[0]));
        hsum_d = sat_add(hsum_q, DELTA_BITS'(rat_q[3]) - DELTA_BITS'(rat_q[1]));
        vsign_d = sign_of(vsum_d, swipe_q);
        hsign_d = sign_of(hsum_d, swipe_q);
        st_d = S_NF;
      end
      S_NF: begin
        still = ((ud_q < 0 ? -ud_q : ud_q) < $signed({1'b0, still_q})) &&
                ((lr_q < 0 ? -lr_q : lr_q) < $signed({1'b0, still_q}));
        zero  = (ud_q == '0) && (lr_q == '0);
        oseen_d = 1'b0;
        if (still) begin
          if (vsign_q == 2'sd0 && hsign_q == 2'sd0) begin
            if (zero) begin
              if (near_q != 8'hFF) near_d = near_q + 8'd1;
            end else if (far_q != 8'hFF) far_d = far_q + 8'd1;
            if (near_d >= 8'(NEAR_LIMIT) && far_d >= 8'(FAR_LIMIT)) begin
              if (zero) prox_d = PROX_NEAR;
              else if (ud_q != '0 && lr_q != '0) prox_d = PROX_FAR;
              oseen_d = 1'b1;
              lastm_d = decode(prox_d, vsign_q, hsign_q, vsum_q, hsum_q, lastm_q);
            end
          end else begin
            if (zero && near_q != 8'hFF) near_d = near_q + 8'd1;
            if (near_d >= 8'(NEAR_LIMIT)) begin
              vsign_d = 2'sd0; hsign_d = 2'sd0; vsum_d = '0; hsum_d = '0;
            end
          end
        end
        count_d = '0;
        st_d = S_IDLE;
        ovalid_d = 1'b1; omot_d = MOT_NONE; odrop_d = 1'b0;
      end
      S_GEND: begin
        ovalid_d = 1'b1; oseen_d = 1'b0; odrop_d = 1'b0;
        omot_d = decode(prox_q, vsign_q, hsign_q, vsum_q, hsum_q, lastm_q);
        count_d = '0; vsum_d = '0; hsum_d = '0; vsign_d = '0; hsign_d = '0;
        near_d = '0; far_d = '0; prox_d = PROX_NONE; lastm_d = MOT_NONE;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      count_q <= '0;
      vsum_q <= '0; hsum_q <= '0; vsign_q <= '0; hsign_q <= '0;
      near_q <= '0; far_q <= '0; prox_q <= PROX_NONE; lastm_q <= MOT_NONE;
      ovalid_q <= 1'b0;
      rvalid_q <= 1'b0;
      valid_level_q <= 8'd10; swipe_q <= 8'd50; still_q <= 8'd20;
    end else begin
      st_q <= st_d;
      count_q <= count_d;
      vsum_q <= vsum_d; hsum_q <= hsum_d; vsign_q <= vsign_d; hsign_q <= hsign_d;
      near_q <= near_d; far_q <= far_d; prox_q <= prox_d; lastm_q <= lastm_d;
      ovalid_q <= ovalid_d;
      rvalid_q <= rvalid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_VALID_LEVEL: valid_level_q <= cfg_data_i;
          CFG_SWIPE_SENS:  swipe_q <= cfg_data_i;
          CFG_STILL_SENS:  still_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; first_q <= first_d; last_q <= last_d;
    first_s_q <= first_s_d; last_s_q <= last_s_d;
    rat_q <= rat_d; dsel_q <= dsel_d;
    ud_q <= ud_d; lr_q <= lr_d;
    omot_q <= omot_d; oseen_q <= oseen_d; odrop_q <= odrop_d;
  end

  assign out_valid_o      = ovalid_q;
  assign motion_o         = omot_q;
  assign near_far_seen_o  = oseen_q;
  assign sample_dropped_o = odrop_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BATCH_DEPTH)) else $error("sample count past depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !accept) else $error("beat taken while busy");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> !(oseen_q && odrop_q)) else $error("both flags set");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_stall_i |=> ovalid_q) else $error("result lost under stall");
`endif
endmodule
`default_nettype wire

// ===== hdl/gdc_ram.sv =====
// Generic single-port write, single-port read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module gdc_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/gdc_ratio_div.sv =====
// Restoring signed divider: truncated (a-b)*100/(a+b), one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gdc_ratio_div (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] a_i,
  input  wire logic [7:0] b_i,
  output logic            done_o,
  output logic signed [gdc_pkg::RATIO_BITS-1:0] ratio_o
);
  import gdc_pkg::*;

  localparam int NumBits = 15;  // |a-b|*100 < 2^15

  logic [14:0] rem_q, rem_d, quo_q, quo_d, num_q, num_d;
  logic [8:0]  den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] trial;
  logic [8:0]  diff;
  logic [7:0]  qmag;

  assign diff  = (a_i >= b_i) ? {1'b0, a_i - b_i} : {1'b0, b_i - a_i};
  assign trial = {rem_q, num_q[14]} - {7'd0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    num_d  = num_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = 15'(diff) * 15'd100;
      den_d  = {1'b0, a_i} + {1'b0, b_i};
      neg_d  = a_i < b_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 4'(NumBits - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[15]) begin
        rem_d = trial[14:0];
        quo_d = {quo_q[13:0], 1'b1};
      end else begin
        rem_d = {rem_q[13:0], num_q[14]};
        quo_d = {quo_q[13:0], 1'b0};
      end
      num_d = {num_q[13:0], 1'b0};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    num_q <= num_d;
    den_q <= den_d;
    neg_q <= neg_d;
    cnt_q <= cnt_d;
  end

  assign qmag    = quo_q[7:0];
  assign ratio_o = neg_q ? -$signed(qmag) : $signed(qmag);
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the four-channel gesture direction classifier.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import gdc_pkg::*;

  localparam int DEPTH      = 32;
  localparam int MIN_SMP    = 4;
  localparam int NEAR_LIM   = 10;
  localparam int FAR_LIM    = 2;
  localparam int SUM_MAX    = 32767;
  localparam int SUM_MIN    = -32768;
  localparam int ITEM_GOAL  = 1750;
  localparam int HOLD_LEN   = 400;
  // Run cap; the worst case, batch ends plus stalls and gaps, stays well under this.
  localparam int CYCLE_CAP  = 1000000;
  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused kind; only yields an empty output beat

  typedef struct packed {
    logic [2:0] motion;
    logic       seen;
    logic       dropped;
  } gesture_beat_t;

  // Tracks gesture state, predicts each output beat and checks it.
  class gesture_scoreboard;
    gesture_beat_t pending_q[$];
    int            errors;
    bit [31:0]     samples[DEPTH];
    int            count;
    int            vert_sum, horz_sum, vert_sign, horz_sign;
    int            near_cnt, far_cnt;
    logic [1:0]    prox;
    logic [2:0]    last_motion;
    bit [7:0]      valid_lvl, swipe_lvl, still_lvl;

    function new();
      errors = 0;
      valid_lvl = 8'd10;
      swipe_lvl = 8'd50;
      still_lvl = 8'd20;
      clear_gesture();
    endfunction

    function void clear_gesture();
      count = 0; vert_sum = 0; horz_sum = 0; vert_sign = 0; horz_sign = 0;
      near_cnt = 0; far_cnt = 0; prox = PROX_NONE; last_motion = MOT_NONE;
    endfunction

    function void set_reg(logic [1:0] idx, bit [7:0] val);
      case (idx)
        CFG_VALID_LEVEL: valid_lvl = val;
        CFG_SWIPE_SENS:  swipe_lvl = val;
        CFG_STILL_SENS:  still_lvl = val;
        default: ;
      endcase
    endfunction

    function bit usable(bit [31:0] s);
      return s[31:24] > valid_lvl && s[23:16] > valid_lvl &&
             s[15:8] > valid_lvl && s[7:0] > valid_lvl;
    endfunction

    // Truncating percent ratio (a-b)*100/(a+b).
    function int pct(int a, int b);
      return ((a - b) * 100) / (a + b);
    endfunction

    function int clamp_sum(int v);
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      return v;
    endfunction

    function int direction(int s);
      if (s >= int'(swipe_lvl)) return 1;
      if (s <= -int'(swipe_lvl)) return -1;
      return 0;
    endfunction

    function int absval(int v);
      return v < 0 ? -v : v;
    endfunction

    function void decode();
      if (prox == PROX_NEAR) begin
        last_motion = MOT_NEAR;
      end else if (prox == PROX_FAR) begin
        last_motion = MOT_FAR;
      end else if (vert_sign == 0 && horz_sign == 0) begin
      end else if (horz_sign == 0 ||
                   (vert_sign != 0 && absval(vert_sum) > absval(horz_sum))) begin
        last_motion = vert_sign < 0 ? MOT_UP : MOT_DOWN;
      end else begin
        last_motion = horz_sign > 0 ? MOT_RIGHT : MOT_LEFT;
      end
    endfunction

    // Batch end; returns 1 when the near/far decision is reached.
    function bit run_batch();
      int  first, last, ud, lr;
      bit  found;
      bit  still;
      first = 0; last = 0; found = 0;
      if (count <= MIN_SMP) return 0;
      for (int i = 0; i < count; i++)
        if (!found && usable(samples[i])) begin
          first = i;
          found = 1;
        end
      if (!found) return 0;
      for (int i = count - 1; i >= 0; i--)
        if (usable(samples[i])) begin
          last = i;
          break;
        end
      ud = pct(samples[last][31:24], samples[last][23:16]) -
           pct(samples[first][31:24], samples[first][23:16]);
      lr = pct(samples[last][15:8], samples[last][7:0]) -
           pct(samples[first][15:8], samples[first][7:0]);
      vert_sum = clamp_sum(vert_sum + ud);
      horz_sum = clamp_sum(horz_sum + lr);
      vert_sign = direction(vert_sum);
      horz_sign = direction(horz_sum);
      still = absval(ud) < int'(still_lvl) && absval(lr) < int'(still_lvl);
      if (!still) return 0;
      if (vert_sign == 0 && horz_sign == 0) begin
        if (ud == 0 && lr == 0) begin
          if (near_cnt < 255) near_cnt++;
        end else if (far_cnt < 255) begin
          far_cnt++;
        end
        if (near_cnt >= NEAR_LIM && far_cnt >= FAR_LIM) begin
          if (ud == 0 && lr == 0) prox = PROX_NEAR;
          else if (ud != 0 && lr != 0) prox = PROX_FAR;
          return 1;
        end
      end else begin
        if (ud == 0 && lr == 0 && near_cnt < 255) near_cnt++;
        if (near_cnt >= NEAR_LIM) begin
          vert_sign = 0; horz_sign = 0; vert_sum = 0; horz_sum = 0;
        end
      end
      return 0;
    endfunction

    function void note_input(logic [1:0] kind, bit [31:0] smp);
      gesture_beat_t exp_beat;
      exp_beat = '0;
      case (kind)
        KIND_SAMPLE: begin
          if (count < DEPTH) begin
            samples[count] = smp;
            count++;
          end else begin
            exp_beat.dropped = 1'b1;
          end
        end
        KIND_BATCH: begin
          if (run_batch()) begin
            exp_beat.seen = 1'b1;
            decode();
          end
          count = 0;
        end
        KIND_END: begin
          decode();
          exp_beat.motion = last_motion;
          clear_gesture();
        end
        default: ;
      endcase
      pending_q.push_back(exp_beat);
    endfunction

    function void report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endfunction

    function void check_result(gesture_beat_t got);
      gesture_beat_t want;
      if (pending_q.size() == 0) begin
        report("output beat with nothing expected");
        return;
      end
      want = pending_q.pop_front();
      if (got.motion !== want.motion)
        report($sformatf("motion %0d, expected %0d", got.motion, want.motion));
      if (got.seen !== want.seen)
        report($sformatf("near_far_seen %0b, expected %0b", got.seen, want.seen));
      if (got.dropped !== want.dropped)
        report($sformatf("sample_dropped %0b, expected %0b", got.dropped, want.dropped));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i = '0;
  logic [7:0] up_level_i = '0;
  logic [7:0] down_level_i = '0;
  logic [7:0] left_level_i = '0;
  logic [7:0] right_level_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] motion_o;
  logic       near_far_seen_o;
  logic       sample_dropped_o;

  gesture_scoreboard sb = new();
  int  items_sent = 0;
  int  cycles = 0;
  bit  calm = 0;      // no idling on either side
  bit  hold_req = 0;  // asks the receiver for one long hold-off
  bit [7:0] vl_now = 8'd10;

  gesture_direction_classifier dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .kind_i, .up_level_i, .down_level_i,
    .left_level_i, .right_level_i, .out_valid_o, .out_stall_i,
    .motion_o, .near_far_seen_o, .sample_dropped_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output monitor: a beat moves when valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{motion_o, near_far_seen_o, sample_dropped_o});
  end

  // Receiver back-pressure: random bursts, plus one long hold on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_req = 0;
      end else if (calm || $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  end

  // One input beat; valid stays high into the next beat unless a gap follows.
  task automatic send(logic [1:0] kind, bit [7:0] u, bit [7:0] d, bit [7:0] l,
                      bit [7:0] r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    up_level_i    <= u;
    down_level_i  <= d;
    left_level_i  <= l;
    right_level_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(kind, {u, d, l, r});
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes all three registers back to back; block must be idle.
  task automatic program_regs(bit [7:0] vl, bit [7:0] sw, bit [7:0] st);
    bit [7:0] vals[3];
    vals = '{vl, sw, st};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      sb.set_reg(2'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    vl_now = vl;
  endtask

  // A level that passes the validity test when that is possible at all.
  function automatic bit [7:0] good_lvl(int hi = 255);
    if (vl_now >= hi) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(vl_now + 1, hi));
  endfunction

  task automatic sample(bit [31:0] s);
    send(KIND_SAMPLE, s[31:24], s[23:16], s[15:8], s[7:0]);
  endtask

  // Batch whose first and last usable samples give the chosen deltas.
  // style 0: identical ends (zero delta), 1: one-step change, 2: random swipe
  task automatic shaped_batch(int style);
    bit [31:0] head, tail;
    int n;
    n = $urandom_range(MIN_SMP + 1, 12);
    head = {good_lvl(254), good_lvl(254), good_lvl(254), good_lvl(254)};
    case (style)
      0: tail = head;
      1: tail = {head[31:24] + 8'd1, head[23:16], head[15:8] + 8'd1, head[7:0]};
      default: tail = {good_lvl(), good_lvl(), good_lvl(), good_lvl()};
    endcase
    sample(head);
    for (int i = 1; i < n - 1; i++) sample($urandom);
    sample(tail);
    send(KIND_BATCH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Mostly well-formed gestures, with some short, blank, overfull and spare beats.
  task automatic random_gesture();
    int nb;
    nb = $urandom_range(1, 16);
    for (int b = 0; b < nb; b++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: shaped_batch(0);
        7, 8, 9, 10:         shaped_batch(1);
        11, 12, 13, 14:      shaped_batch(2);
        15: begin  // too few samples
          repeat ($urandom_range(0, MIN_SMP)) sample($urandom);
          send(KIND_BATCH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        16: begin  // nothing above the valid level
          repeat ($urandom_range(5, 10))
            sample({4{8'($urandom_range(0, vl_now))}} ^
                   {7'd0, 1'($urandom_range(0, 1)), 24'd0});
          send(KIND_BATCH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        17: begin  // overflows the buffer one time in four
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(DEPTH + 1, DEPTH + 4)) sample($urandom);
            send(KIND_BATCH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          end
        end
        18: send(KIND_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: repeat ($urandom_range(1, 8)) sample($urandom);
      endcase
    end
    send(KIND_END, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic random_phase(int goal);
    while (items_sent < goal) random_gesture();
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: spare kind, empty gesture, short batch, extreme ratios.
    send(KIND_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send(KIND_END, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (MIN_SMP) sample(32'h8080_8080);
    send(KIND_BATCH, 8'h00, 8'h00, 8'h00, 8'h00);
    sample(32'h0000_0000);
    sample(32'hFF0B_0BFF);
    sample(32'h7878_7878);
    sample(32'h0A0A_0A0A);
    sample(32'h0BFF_FF0B);
    send(KIND_BATCH, 8'h00, 8'h00, 8'h00, 8'h00);
    send(KIND_END, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    program_regs(8'd10, 8'd50, 8'd20);
    // Long one-way swipe: vertical sum saturates high, horizontal low.
    for (int b = 0; b < 185; b++) begin
      sample(32'h0BFF_FF0B);
      repeat (3) sample($urandom);
      sample(32'hFF0B_0BFF);
      send(KIND_BATCH, 8'h00, 8'h00, 8'h00, 8'h00);
    end
    send(KIND_END, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    hold_req = 1;  // receiver stalls while the sender keeps offering beats
    random_phase(items_sent + 120);
    program_regs(8'd0, 8'd0, 8'd0);
    random_phase(items_sent + 80);
    program_regs(8'd255, 8'd255, 8'd255);
    random_phase(items_sent + 40);
    program_regs(8'd0, 8'd255, 8'd255);
    random_phase(items_sent + 90);
    program_regs(8'd200, 8'd1, 8'd255);
    random_phase(items_sent + 60);
    program_regs(8'($urandom_range(0, 60)), 8'($urandom), 8'($urandom));
    random_phase(items_sent + 60);
    program_regs(8'd10, 8'd50, 8'd20);
    random_phase(ITEM_GOAL - 150);
    calm = 1;
    random_phase(ITEM_GOAL);

    repeat (200) @(posedge clk_i);
    if (sb.pending_q.size() != 0) sb.report("expected beats never arrived");
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/gdc_pkg.sv
hdl/gdc_ram.sv
hdl/gdc_ratio_div.sv
hdl/gesture_direction_classifier.sv
tb/tb_top.sv
